// ----- design/fractal_value_noise_pixel_core_macros.svh -----
// ----------------------------------------------------------------------------
// Fractal value noise pixel core: assertion macros
// Shared property forms for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_PIXEL_CORE_MACROS_SVH
`define FRACTAL_VALUE_NOISE_PIXEL_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FVNP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fvnp assertion failed");

// Next-cycle implication, disabled during reset.
`define FVNP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fvnp assertion failed");

`endif

// ----- design/fvnp_pkg.sv -----
// ----------------------------------------------------------------------------
// Fractal value noise pixel package
// Types, constants and the cosine weight generator shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fvnp_pkg;

   localparam int DIVIDEND_BITS = 19;
   localparam int DIVISOR_BITS  = 8;

   localparam logic CSR_OCTAVE_COUNT    = 1'b0;
   localparam logic CSR_WAVELENGTH_LOG2 = 1'b1;

   localparam logic [31:0] HASH_MUL_A = 32'd15731;
   localparam logic [31:0] HASH_ADD_A = 32'd789221;
   localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
   localparam logic [31:0] HASH_MASK  = 32'h7fffffff;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_SEED,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_MUL4,
      S_ACCUM,
      S_BLEND0,
      S_BLEND1,
      S_BLEND2,
      S_FINAL,
      S_DIVIDE
   } state_type;

   typedef struct packed {
      logic                     start;
      logic [DIVIDEND_BITS-1:0] dividend;
      logic [DIVISOR_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic [DIVIDEND_BITS-1:0] quotient;
   } div_rsp_type;

   // Quotient truncated toward zero for a positive divisor, by shift and subtract.
   function automatic longint div_trunc(input longint num, input longint den);
      longint mag;
      longint quo;
      longint rem;
      mag = (num < 0) ? -num : num;
      quo = 0;
      rem = 0;
      for (int idx = 62; idx >= 0; idx--) begin
         rem = (rem <<< 1) | ((mag >>> idx) & 64'sd1);
         quo = quo <<< 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'sd1;
         end
      end
      return (num < 0) ? -quo : quo;
   endfunction

   // Half-range weight (1 - cos(theta)) / 4 on a 65536 scale, by a Horner series in Q30.
   function automatic logic [16:0] half_weight(input int k, input int bits);
      longint q30;
      longint th;
      longint s;
      longint r;
      longint d;
      q30 = 64'sd1 << 30;
      th  = (64'sd3373259426 * longint'(k)) >>> bits;
      s   = (th * th) >>> 30;
      r   = q30;
      r   = q30 - div_trunc(s * r, 64'sd132 * q30);
      r   = q30 - div_trunc(s * r, 64'sd90 * q30);
      r   = q30 - div_trunc(s * r, 64'sd56 * q30);
      r   = q30 - div_trunc(s * r, 64'sd30 * q30);
      r   = q30 - div_trunc(s * r, 64'sd12 * q30);
      r   = q30 - div_trunc(s * r, 64'sd2 * q30);
      d   = q30 - r;
      if (d < 0) begin
         d = 0;
      end
      return 17'((d + 64'sd32768) >>> 16);
   endfunction

   function automatic logic [16:0] cos_entry(input int k, input int bits);
      int n;
      n = 1 << bits;
      if (k <= (n >> 1)) begin
         return half_weight(k, bits);
      end
      return 17'(65536 - int'(half_weight(n - k, bits)));
   endfunction

endpackage

// ----- design/fvnp_div.sv -----
// ----------------------------------------------------------------------------
// Fractal value noise pixel divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvnp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fvnp_pkg::div_req_type div_req,
   output fvnp_pkg::div_rsp_type div_rsp
);

   localparam int NB = fvnp_pkg::DIVIDEND_BITS;
   localparam int DB = fvnp_pkg::DIVISOR_BITS;
   localparam int CB = $clog2(NB + 1);

   logic [NB-1:0] quo_ff, quo_in;
   logic [DB-1:0] rem_ff, rem_in;
   logic [DB-1:0] den_ff, den_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [DB:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NB-1]};
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         den_in = div_req.divisor;
         cnt_in = CB'(NB);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DB'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial[DB-1:0];
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CB'(1);
         if (cnt_ff == CB'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- design/fractal_value_noise_pixel_core.sv -----
// ----------------------------------------------------------------------------
// Fractal value noise pixel core
// Sequencer around one shared multiplier that turns a pixel into a height.
// ----------------------------------------------------------------------------
// Usage: raise start with req_pixel_x / req_pixel_y while busy is low; the
// request is taken at that clock edge and busy stays high until the result.
// The result appears on rsp_height_value for exactly one cycle, marked by
// rsp_valid, and must be taken then; the receiver cannot stall the core.
// Configuration is written through csr_we / csr_index / csr_wdata while the
// core is idle: index 0 is the octave count, index 1 the base wavelength.
// Each octave hashes 36 lattice points (S_SEED, S_MUL1 to S_MUL4, S_ACCUM),
// all on one 34 x 34 multiplier, then runs three blend steps on the same
// multiplier; a restoring divider normalizes the final sum. One request is
// in flight at a time. Reset (synchronous) returns the core to idle and
// loads octave count 6 and wavelength 7.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fractal_value_noise_pixel_core_macros.svh"

module fractal_value_noise_pixel_core #(
   parameter int COORD_BITS     = 9,
   parameter int COS_TABLE_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_pixel_x,
   input  logic [COORD_BITS-1:0] req_pixel_y,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_height_value,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [3:0]            csr_wdata
);

   localparam int COS_N = 1 << COS_TABLE_BITS;

   // Cosine weight table, built at elaboration.
   logic [16:0] cos_rom [COS_N];
   for (genvar k = 0; k < COS_N; k++) begin : g_cos
      localparam logic [16:0] WEIGHT = fvnp_pkg::cos_entry(k, COS_TABLE_BITS);
      assign cos_rom[k] = WEIGHT;
   end

   fvnp_pkg::state_type state_ff, state_in;

   logic [3:0]            oct_cfg_ff, oct_cfg_in;
   logic [3:0]            wl_cfg_ff, wl_cfg_in;
   logic [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [3:0]            n_ff, n_in, wl_ff, wl_in;
   logic [7:0]            den_ff, den_in;
   logic [2:0]            oct_ff, oct_in;
   logic [31:0]           lx_ff, lx_in, ly_ff, ly_in;
   logic [16:0]           wx_ff, wx_in, wy_ff, wy_in;
   logic [1:0]            cell_ff, cell_in;
   logic [1:0]            nbx_ff, nbx_in, nby_ff, nby_in;
   logic [31:0]           x_ff, x_in, y_ff, y_in, seed_ff, seed_in;
   logic [31:0]           n_hash_ff, n_hash_in, p_ff, p_in, t_ff, t_in;
   logic signed [21:0]    sum_ff, sum_in;
   logic signed [17:0]    sm_ff [4];
   logic signed [17:0]    sm_in [4];
   logic signed [19:0]    va_ff, va_in, vb_ff, vb_in;
   logic signed [27:0]    acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_height_ff, rsp_height_in;

   logic signed [33:0]    mul_a, mul_b;
   logic signed [67:0]    mul_p;
   logic signed [19:0]    blend_a, blend_b, blend_out;
   logic signed [20:0]    blend_d;
   logic [16:0]           blend_w;

   logic [31:0]           px32, py32, cmask, fx_w, fy_w, n_mix;
   logic [3:0]            sh, up;
   logic signed [17:0]    lat_v;
   logic signed [21:0]    lat_w, sum_next;
   logic [1:0]            nb_kind;
   logic signed [28:0]    num;
   logic [35:0]           num255;
   logic [3:0]            n_clamp;

   fvnp_pkg::div_req_type div_req;
   fvnp_pkg::div_rsp_type div_rsp;

   fvnp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign mul_p = mul_a * mul_b;

   // Blend a + floor((b - a) * w / 65536) on the shared multiplier.
   assign blend_d   = 21'(blend_b) - 21'(blend_a);
   assign blend_out = 20'(21'(blend_a) + 21'(mul_p[36:16]));

   always_comb begin
      state_in      = state_ff;
      oct_cfg_in    = oct_cfg_ff;
      wl_cfg_in     = wl_cfg_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      n_in          = n_ff;
      wl_in         = wl_ff;
      den_in        = den_ff;
      oct_in        = oct_ff;
      lx_in         = lx_ff;
      ly_in         = ly_ff;
      wx_in         = wx_ff;
      wy_in         = wy_ff;
      cell_in       = cell_ff;
      nbx_in        = nbx_ff;
      nby_in        = nby_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      seed_in       = seed_ff;
      n_hash_in     = n_hash_ff;
      p_in          = p_ff;
      t_in          = t_ff;
      sum_in        = sum_ff;
      sm_in         = sm_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = 1'b0;
      rsp_height_in = rsp_height_ff;
      mul_a         = '0;
      mul_b         = '0;
      blend_a       = '0;
      blend_b       = '0;
      blend_w       = '0;
      div_req       = '0;

      px32  = 32'(px_ff);
      py32  = 32'(py_ff);
      sh    = wl_ff - {1'b0, oct_ff};
      up    = {1'b0, oct_ff} - wl_ff;
      cmask = (32'd1 << sh) - 32'd1;
      fx_w  = (px32 & cmask) << (5'd16 - {1'b0, sh});
      fy_w  = (py32 & cmask) << (5'd16 - {1'b0, sh});
      n_mix = x_ff + mul_p[31:0];

      lat_v   = 18'sd65536 - $signed({1'b0, t_ff[30:14]});
      nb_kind = 2'(nbx_ff == 2'd1) + 2'(nby_ff == 2'd1);
      lat_w   = 22'(lat_v) <<< nb_kind;
      sum_next = sum_ff + lat_w;

      num     = 29'(acc_ff) + $signed({5'b0, den_ff, 16'b0});
      num255  = {num[27:0], 8'b0} - {8'b0, num[27:0]};
      n_clamp = (oct_cfg_ff == 4'd0) ? 4'd1 : (oct_cfg_ff > 4'd8) ? 4'd8 : oct_cfg_ff;

      if (csr_we) begin
         case (csr_index)
            fvnp_pkg::CSR_OCTAVE_COUNT:    oct_cfg_in = csr_wdata;
            fvnp_pkg::CSR_WAVELENGTH_LOG2: wl_cfg_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         fvnp_pkg::S_IDLE: begin
            if (start) begin
               px_in    = req_pixel_x;
               py_in    = req_pixel_y;
               n_in     = n_clamp;
               wl_in    = (wl_cfg_ff > 4'd12) ? 4'd12 : wl_cfg_ff;
               den_in   = 8'((9'd1 << n_clamp) - 9'd1);
               oct_in   = '0;
               acc_in   = '0;
               state_in = fvnp_pkg::S_SETUP;
            end
         end
         fvnp_pkg::S_SETUP: begin
            if ({1'b0, oct_ff} <= wl_ff) begin
               lx_in = px32 >> sh;
               ly_in = py32 >> sh;
               wx_in = cos_rom[fx_w[15 -: COS_TABLE_BITS]];
               wy_in = cos_rom[fy_w[15 -: COS_TABLE_BITS]];
            end else begin
               lx_in = px32 << up;
               ly_in = py32 << up;
               wx_in = cos_rom[0];
               wy_in = cos_rom[0];
            end
            cell_in  = '0;
            nbx_in   = '0;
            nby_in   = '0;
            sum_in   = '0;
            state_in = fvnp_pkg::S_SEED;
         end
         fvnp_pkg::S_SEED: begin
            x_in     = lx_ff + 32'(cell_ff[0]) + 32'(nbx_ff) - 32'd1;
            y_in     = ly_ff + 32'(cell_ff[1]) + 32'(nby_ff) - 32'd1;
            seed_in  = x_in + (y_in << 5) - y_in;
            state_in = fvnp_pkg::S_MUL1;
         end
         fvnp_pkg::S_MUL1: begin
            mul_a     = $signed({2'b0, y_ff});
            mul_b     = $signed({2'b0, seed_ff});
            n_hash_in = (n_mix << 13) ^ n_mix;
            state_in  = fvnp_pkg::S_MUL2;
         end
         fvnp_pkg::S_MUL2: begin
            mul_a    = $signed({2'b0, n_hash_ff});
            mul_b    = $signed({2'b0, n_hash_ff});
            p_in     = mul_p[31:0];
            state_in = fvnp_pkg::S_MUL3;
         end
         fvnp_pkg::S_MUL3: begin
            mul_a    = $signed({2'b0, p_ff});
            mul_b    = $signed({2'b0, fvnp_pkg::HASH_MUL_A});
            p_in     = mul_p[31:0] + fvnp_pkg::HASH_ADD_A;
            state_in = fvnp_pkg::S_MUL4;
         end
         fvnp_pkg::S_MUL4: begin
            mul_a    = $signed({2'b0, n_hash_ff});
            mul_b    = $signed({2'b0, p_ff});
            t_in     = (mul_p[31:0] + fvnp_pkg::HASH_ADD_B) & fvnp_pkg::HASH_MASK;
            state_in = fvnp_pkg::S_ACCUM;
         end
         fvnp_pkg::S_ACCUM: begin
            state_in = fvnp_pkg::S_SEED;
            if (nbx_ff != 2'd2) begin
               nbx_in = nbx_ff + 2'd1;
               sum_in = sum_next;
            end else if (nby_ff != 2'd2) begin
               nbx_in = '0;
               nby_in = nby_ff + 2'd1;
               sum_in = sum_next;
            end else begin
               // Ninth neighbor: the smoothed value of this cell is complete.
               nbx_in         = '0;
               nby_in         = '0;
               sum_in         = '0;
               sm_in[cell_ff] = sum_next[21:4];
               cell_in        = cell_ff + 2'd1;
               if (cell_ff == 2'd3) begin
                  state_in = fvnp_pkg::S_BLEND0;
               end
            end
         end
         fvnp_pkg::S_BLEND0: begin
            blend_a  = 20'(sm_ff[0]);
            blend_b  = 20'(sm_ff[1]);
            blend_w  = wx_ff;
            mul_a    = 34'(blend_d);
            mul_b    = $signed({17'b0, blend_w});
            va_in    = blend_out;
            state_in = fvnp_pkg::S_BLEND1;
         end
         fvnp_pkg::S_BLEND1: begin
            blend_a  = 20'(sm_ff[2]);
            blend_b  = 20'(sm_ff[3]);
            blend_w  = wx_ff;
            mul_a    = 34'(blend_d);
            mul_b    = $signed({17'b0, blend_w});
            vb_in    = blend_out;
            state_in = fvnp_pkg::S_BLEND2;
         end
         fvnp_pkg::S_BLEND2: begin
            blend_a  = va_ff;
            blend_b  = vb_ff;
            blend_w  = wy_ff;
            mul_a    = 34'(blend_d);
            mul_b    = $signed({17'b0, blend_w});
            // Horner form gives octave i the weight 2^(n-1-i).
            acc_in   = (acc_ff <<< 1) + 28'(blend_out);
            oct_in   = oct_ff + 3'd1;
            if ({1'b0, oct_ff} == n_ff - 4'd1) begin
               state_in = fvnp_pkg::S_FINAL;
            end else begin
               state_in = fvnp_pkg::S_SETUP;
            end
         end
         fvnp_pkg::S_FINAL: begin
            if (num < 0) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = '0;
               state_in      = fvnp_pkg::S_IDLE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = num255[35:17];
               div_req.divisor  = den_ff;
               state_in         = fvnp_pkg::S_DIVIDE;
            end
         end
         fvnp_pkg::S_DIVIDE: begin
            if (div_rsp.done) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = (div_rsp.quotient > 19'd255) ? 8'd255
                                                             : div_rsp.quotient[7:0];
               state_in      = fvnp_pkg::S_IDLE;
            end
         end
         default: state_in = fvnp_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fvnp_pkg::S_IDLE;
         oct_cfg_ff   <= 4'd6;
         wl_cfg_ff    <= 4'd7;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oct_cfg_ff   <= oct_cfg_in;
         wl_cfg_ff    <= wl_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff         <= px_in;
      py_ff         <= py_in;
      n_ff          <= n_in;
      wl_ff         <= wl_in;
      den_ff        <= den_in;
      oct_ff        <= oct_in;
      lx_ff         <= lx_in;
      ly_ff         <= ly_in;
      wx_ff         <= wx_in;
      wy_ff         <= wy_in;
      cell_ff       <= cell_in;
      nbx_ff        <= nbx_in;
      nby_ff        <= nby_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      seed_ff       <= seed_in;
      n_hash_ff     <= n_hash_in;
      p_ff          <= p_in;
      t_ff          <= t_in;
      sum_ff        <= sum_in;
      sm_ff         <= sm_in;
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      acc_ff        <= acc_in;
      rsp_height_ff <= rsp_height_in;
   end

   assign busy             = (state_ff != fvnp_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_height_value = rsp_height_ff;

   `FVNP_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy)
   `FVNP_ASSERT_NXT(a_rsp_strobe, clock, reset, rsp_valid, !rsp_valid)
   `FVNP_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `FVNP_ASSERT_NXT(a_div_rsp, clock, reset, div_rsp.done, rsp_valid)

endmodule
